// File: rtl/core/rtt_pkg.sv
// rtt_pkg: types, constants and codes shared by the retransmit timer table
// covers the transfer structs, table entry layout, operation and status codes
// no dependencies

package rtt_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // configuration port geometry
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // register indexes (address bit 2)
  localparam logic [0:0] REG_MAX_SENDS  = 1'b0;
  localparam logic [0:0] REG_WAIT_TICKS = 1'b1;

  // register reset values
  localparam logic [7:0]  MAX_SENDS_RST  = 8'd3;
  localparam logic [15:0] WAIT_TICKS_RST = 16'd10;

  // saturation limits
  localparam logic [7:0]  SEND_MAX = 8'hFF;
  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_PRESENT     = 3'd2,
    ST_FULL        = 3'd3,
    ST_RETRY_LIMIT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] cmd;
    logic [31:0] server_time;
    logic [31:0] packet_index;
    logic [7:0]  frame_handle;
  } in_item_t;

  typedef struct packed {
    logic        resend;
    logic [15:0] cmd_out;
    logic [31:0] time_out;
    logic [31:0] index_out;
    logic [7:0]  handle_out;
    status_e     status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  max_sends;
    logic [15:0] wait_ticks;
  } cfg_t;

  // one table slot as seen on the read port
  typedef struct packed {
    logic        valid;
    logic [15:0] cmd;
    logic [31:0] server_time;
    logic [31:0] packet_index;
    logic [7:0]  handle;
    logic [7:0]  send_count;
    logic [15:0] wait_count;
  } entry_t;

  // write port: valid bit, key and handle, counts, each with its own enable
  typedef struct packed {
    logic             valid_we;
    logic             key_we;
    logic             cnt_we;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } wr_t;

endpackage

// File: rtl/core/rtt_cfg_regs.sv
// rtt_cfg_regs: apb-style register file for the retry and wait limits
// depends on rtt_pkg for the port geometry, register indexes and cfg_t

module rtt_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtt_pkg::PADDR_W-1:0]  paddr,
  input  logic [rtt_pkg::PDATA_W-1:0]  pwdata,
  output logic [rtt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output rtt_pkg::cfg_t                cfg_o
);

  rtt_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2:2])
        rtt_pkg::REG_MAX_SENDS:  cfg_d.max_sends  = pwdata[7:0];
        rtt_pkg::REG_WAIT_TICKS: cfg_d.wait_ticks = pwdata[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_sends  <= rtt_pkg::MAX_SENDS_RST;
      cfg_q.wait_ticks <= rtt_pkg::WAIT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back
  always_comb begin
    unique case (paddr[2:2])
      rtt_pkg::REG_MAX_SENDS:  prdata = {{(rtt_pkg::PDATA_W-8){1'b0}}, cfg_q.max_sends};
      rtt_pkg::REG_WAIT_TICKS: prdata = {{(rtt_pkg::PDATA_W-16){1'b0}}, cfg_q.wait_ticks};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/rtt_store.sv
// rtt_store: slot storage of the table, one read and one write port
// depends on rtt_pkg for the entry layout and write port struct

module rtt_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [rtt_pkg::IDX_W-1:0] rd_idx_i,
  output rtt_pkg::entry_t           rd_o,
  input  rtt_pkg::wr_t              wr_i
);

  logic [rtt_pkg::TABLE_DEPTH-1:0] valid_q;
  logic [15:0] cmd_q    [rtt_pkg::TABLE_DEPTH];
  logic [31:0] time_q   [rtt_pkg::TABLE_DEPTH];
  logic [31:0] index_q  [rtt_pkg::TABLE_DEPTH];
  logic [7:0]  handle_q [rtt_pkg::TABLE_DEPTH];
  logic [7:0]  send_q   [rtt_pkg::TABLE_DEPTH];
  logic [15:0] wait_q   [rtt_pkg::TABLE_DEPTH];

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.valid_we) begin
      valid_q[wr_i.idx] <= wr_i.data.valid;
    end
  end

  // key, handle and counts, meaningful only under a set valid bit
  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) begin
      cmd_q[wr_i.idx]    <= wr_i.data.cmd;
      time_q[wr_i.idx]   <= wr_i.data.server_time;
      index_q[wr_i.idx]  <= wr_i.data.packet_index;
      handle_q[wr_i.idx] <= wr_i.data.handle;
    end
    if (wr_i.cnt_we) begin
      send_q[wr_i.idx] <= wr_i.data.send_count;
      wait_q[wr_i.idx] <= wr_i.data.wait_count;
    end
  end

  // slot read at the scan position
  always_comb begin
    rd_o.valid        = valid_q[rd_idx_i];
    rd_o.cmd          = cmd_q[rd_idx_i];
    rd_o.server_time  = time_q[rd_idx_i];
    rd_o.packet_index = index_q[rd_idx_i];
    rd_o.handle       = handle_q[rd_idx_i];
    rd_o.send_count   = send_q[rd_idx_i];
    rd_o.wait_count   = wait_q[rd_idx_i];
  end

endmodule

// File: rtl/core/rtt_ctrl.sv
// rtt_ctrl: sequencer that walks the slots through one shared compare unit
// depends on rtt_pkg; drives the store ports and the output register

module rtt_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rtt_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rtt_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rtt_pkg::out_item_t        out_item_o,
  output logic [rtt_pkg::IDX_W-1:0] rd_idx_o,
  input  rtt_pkg::entry_t           rd_i,
  output rtt_pkg::wr_t              wr_o
);

  rtt_pkg::state_e            state_q, state_d;
  rtt_pkg::in_item_t          item_q, item_d;
  logic [rtt_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                       found_q, found_d;
  logic                       free_found_q, free_found_d;
  logic [rtt_pkg::IDX_W-1:0]  free_idx_q, free_idx_d;
  rtt_pkg::out_item_t         res_q, res_d;
  rtt_pkg::out_item_t         out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic key_hit, last_slot, over_send, over_wait, out_free;
  logic tick_stall, scan_stop, found_all, free_all;
  logic [rtt_pkg::IDX_W-1:0] ins_idx;

  // shared compare unit on the slot under the scan pointer
  assign key_hit   = rd_i.valid && (rd_i.cmd == item_q.cmd) &&
                     (rd_i.server_time == item_q.server_time) &&
                     (rd_i.packet_index == item_q.packet_index);
  assign over_send = rd_i.send_count > cfg_i.max_sends;
  assign over_wait = rd_i.wait_count > cfg_i.wait_ticks;
  assign last_slot = idx_q == rtt_pkg::IDX_W'(rtt_pkg::TABLE_DEPTH - 1);
  assign out_free  = !out_valid_q || out_ready_i;

  // insert outcome over the whole walk, this slot included
  assign found_all = found_q || key_hit;
  assign free_all  = free_found_q || !rd_i.valid;
  assign ins_idx   = free_found_q ? free_idx_q : idx_q;

  // a resend waits while the output register is still occupied
  assign tick_stall = (state_q == rtt_pkg::S_SCAN) && (item_q.func == rtt_pkg::FUNC_TICK) &&
                      rd_i.valid && !over_send && over_wait && !out_free;

  // walk ends on this cycle
  always_comb begin
    scan_stop = 1'b0;
    if (state_q == rtt_pkg::S_SCAN) begin
      unique case (item_q.func)
        rtt_pkg::FUNC_INSERT: scan_stop = last_slot;
        rtt_pkg::FUNC_DELETE,
        rtt_pkg::FUNC_LOOKUP: scan_stop = key_hit || last_slot;
        rtt_pkg::FUNC_TICK:   scan_stop = (rd_i.valid && over_send) ||
                                          (last_slot && !tick_stall);
        default:              scan_stop = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtt_pkg::S_IDLE: if (in_valid_i) state_d = rtt_pkg::S_SCAN;
      rtt_pkg::S_SCAN: if (scan_stop)  state_d = rtt_pkg::S_DONE;
      rtt_pkg::S_DONE: if (out_free)   state_d = rtt_pkg::S_IDLE;
      default:         state_d = rtt_pkg::S_IDLE;
    endcase
  end

  // datapath, store writes and result loading
  always_comb begin
    item_d       = item_q;
    idx_d        = idx_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    wr_o         = '0;
    wr_o.idx     = idx_q;

    unique case (state_q)
      rtt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_d       = in_item_i;
          idx_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          free_idx_d   = '0;
        end
      end

      rtt_pkg::S_SCAN: begin
        if (!tick_stall) idx_d = idx_q + 1'b1;
        unique case (item_q.func)
          rtt_pkg::FUNC_INSERT: begin
            if (key_hit) found_d = 1'b1;
            if (!rd_i.valid && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = idx_q;
            end
            if (last_slot) begin
              res_d      = '0;
              res_d.last = 1'b1;
              if (found_all) begin
                res_d.status = rtt_pkg::ST_PRESENT;
              end else if (free_all) begin
                res_d.status           = rtt_pkg::ST_OK;
                wr_o.valid_we          = 1'b1;
                wr_o.key_we            = 1'b1;
                wr_o.cnt_we            = 1'b1;
                wr_o.idx               = ins_idx;
                wr_o.data.valid        = 1'b1;
                wr_o.data.cmd          = item_q.cmd;
                wr_o.data.server_time  = item_q.server_time;
                wr_o.data.packet_index = item_q.packet_index;
                wr_o.data.handle       = item_q.frame_handle;
                wr_o.data.send_count   = '0;
                wr_o.data.wait_count   = '0;
              end else begin
                res_d.status = rtt_pkg::ST_FULL;
              end
            end
          end

          rtt_pkg::FUNC_DELETE,
          rtt_pkg::FUNC_LOOKUP: begin
            if (key_hit || last_slot) begin
              res_d        = '0;
              res_d.last   = 1'b1;
              res_d.status = key_hit ? rtt_pkg::ST_OK : rtt_pkg::ST_NOT_FOUND;
            end
            if (key_hit) begin
              if (item_q.func == rtt_pkg::FUNC_DELETE) begin
                wr_o.valid_we   = 1'b1;
                wr_o.data.valid = 1'b0;
              end else begin
                res_d.handle_out = rd_i.handle;
              end
            end
          end

          rtt_pkg::FUNC_TICK: begin
            // normal end of the walk
            if (last_slot) begin
              res_d      = '0;
              res_d.last = 1'b1;
            end
            if (rd_i.valid) begin
              if (over_send) begin
                // retry limit stops the walk at this entry
                res_d            = '0;
                res_d.cmd_out    = rd_i.cmd;
                res_d.time_out   = rd_i.server_time;
                res_d.index_out  = rd_i.packet_index;
                res_d.handle_out = rd_i.handle;
                res_d.status     = rtt_pkg::ST_RETRY_LIMIT;
                res_d.last       = 1'b1;
              end else if (over_wait) begin
                if (out_free) begin
                  wr_o.cnt_we          = 1'b1;
                  wr_o.data.wait_count = '0;
                  wr_o.data.send_count = (rd_i.send_count == rtt_pkg::SEND_MAX) ?
                                         rtt_pkg::SEND_MAX : rd_i.send_count + 1'b1;
                  out_d            = '0;
                  out_d.resend     = 1'b1;
                  out_d.cmd_out    = rd_i.cmd;
                  out_d.time_out   = rd_i.server_time;
                  out_d.index_out  = rd_i.packet_index;
                  out_d.handle_out = rd_i.handle;
                  out_d.status     = rtt_pkg::ST_OK;
                  out_valid_d      = 1'b1;
                end
              end else begin
                wr_o.cnt_we          = 1'b1;
                wr_o.data.send_count = rd_i.send_count;
                wr_o.data.wait_count = (rd_i.wait_count == rtt_pkg::WAIT_MAX) ?
                                       rtt_pkg::WAIT_MAX : rd_i.wait_count + 1'b1;
              end
            end
          end

          default: ;
        endcase
      end

      rtt_pkg::S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rtt_pkg::S_IDLE;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = state_q == rtt_pkg::S_IDLE;
  assign rd_idx_o    = idx_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/core/retransmit_timer_table.sv
// retransmit_timer_table: top level of the retransmission timer table
// depends on rtt_pkg, rtt_cfg_regs, rtt_store and rtt_ctrl
//
// Usage: an input transfer (in_valid_i/in_ready_o, in_item_i) carries one
// operation: insert, delete, lookup or tick. Results leave on the output
// channel (out_valid_o/out_ready_i, out_item_o); the last result of an
// operation has last set. Insert, delete and lookup give one result, a tick
// gives one result per resent entry and then a closing one.
// Flow: the operation is accepted, then the slots are walked, one slot a cycle
// while no resend waits for the output register, through a single key and
// count compare unit. Insert walks every slot, delete and lookup stop at the
// matching slot, and a tick walks every slot unless the retry limit stops it
// early. in_ready_o is high only between operations, so a new operation is
// not accepted before the walk of the last one has finished.
// The output register holds a finished result, so the next operation is
// accepted while it waits; a stalled receiver freezes the tick walk at a
// slot that is due for resend until the output register frees up.
// Reset clears every valid bit at once and restores the register defaults
// (max_sends 3, wait_ticks 10); no clearing pass is needed.
// Registers: max_sends at address 0, wait_ticks at address 4; write them
// only while no operation is in progress.

module retransmit_timer_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rtt_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rtt_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtt_pkg::PADDR_W-1:0]  paddr,
  input  logic [rtt_pkg::PDATA_W-1:0]  pwdata,
  output logic [rtt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  rtt_pkg::cfg_t             cfg;
  rtt_pkg::entry_t           rd_entry;
  rtt_pkg::wr_t              wr;
  logic [rtt_pkg::IDX_W-1:0] rd_idx;

  // configuration registers
  rtt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // slot storage
  rtt_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_entry),
    .wr_i     (wr)
  );

  // sequencer and compare unit
  rtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd_entry),
    .wr_o        (wr)
  );

endmodule

// File: dv/retransmit_timer_table_checker.sv
// retransmit_timer_table_checker: watches the operation, result and register
// transfers of the timer table, keeps a mirror of the table and compares results
// depends on rtt_pkg
`timescale 1ns / 100ps

module retransmit_timer_table_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  rtt_pkg::in_item_t             in_item_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  rtt_pkg::out_item_t            out_item_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [rtt_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [rtt_pkg::PDATA_W-1:0]   pwdata_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_o,
  output int                            resends_o,
  output int                            limit_stops_o
);

  // mirror of the table and its registers
  logic [rtt_pkg::TABLE_DEPTH-1:0] used;
  logic [15:0]            slot_cmd    [rtt_pkg::TABLE_DEPTH];
  logic [31:0]            slot_time   [rtt_pkg::TABLE_DEPTH];
  logic [31:0]            slot_index  [rtt_pkg::TABLE_DEPTH];
  logic [7:0]             slot_handle [rtt_pkg::TABLE_DEPTH];
  logic [7:0]             slot_sends  [rtt_pkg::TABLE_DEPTH];
  logic [15:0]            slot_waits  [rtt_pkg::TABLE_DEPTH];
  rtt_pkg::cfg_t          cfg;

  // results still owed by the table, oldest first
  rtt_pkg::out_item_t     owed_results[$];

  int mismatches  = 0;
  int checked     = 0;
  int resends     = 0;
  int limit_stops = 0;

  assign fail_count_o  = mismatches;
  assign results_o     = checked;
  assign resends_o     = resends;
  assign limit_stops_o = limit_stops;

  // lowest valid slot holding the key, or -1
  function automatic int find_key(input rtt_pkg::in_item_t op);
    int hit;
    int i;
    hit = -1;
    for (i = rtt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (used[i] && slot_cmd[i] == op.cmd && slot_time[i] == op.server_time &&
          slot_index[i] == op.packet_index) begin
        hit = i;
      end
    end
    return hit;
  endfunction

  // apply one operation to the mirror and queue the results it owes
  task automatic apply_table_op(input rtt_pkg::in_item_t op);
    int                 slot;
    int                 i;
    bit                 halted;
    rtt_pkg::out_item_t res;
    rtt_pkg::out_item_t note;
    res      = '0;
    res.last = 1'b1;
    case (op.func)
      rtt_pkg::FUNC_INSERT: begin
        slot = find_key(op);
        if (slot >= 0) begin
          res.status = rtt_pkg::ST_PRESENT;
        end else begin
          for (i = rtt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!used[i]) slot = i;
          end
          if (slot < 0) begin
            res.status = rtt_pkg::ST_FULL;
          end else begin
            used[slot]        = 1'b1;
            slot_cmd[slot]    = op.cmd;
            slot_time[slot]   = op.server_time;
            slot_index[slot]  = op.packet_index;
            slot_handle[slot] = op.frame_handle;
            slot_sends[slot]  = 8'd0;
            slot_waits[slot]  = 16'd0;
          end
        end
      end
      rtt_pkg::FUNC_DELETE: begin
        slot = find_key(op);
        if (slot < 0) res.status = rtt_pkg::ST_NOT_FOUND;
        else used[slot] = 1'b0;
      end
      rtt_pkg::FUNC_LOOKUP: begin
        slot = find_key(op);
        if (slot < 0) res.status = rtt_pkg::ST_NOT_FOUND;
        else res.handle_out = slot_handle[slot];
      end
      default: begin
        // tick: walk the slots in index order
        halted = 1'b0;
        for (i = 0; i < rtt_pkg::TABLE_DEPTH; i++) begin
          if (used[i] && !halted) begin
            if (slot_sends[i] > cfg.max_sends) begin
              // retry limit reached, this entry and later ones stay as they are
              halted         = 1'b1;
              res.cmd_out    = slot_cmd[i];
              res.time_out   = slot_time[i];
              res.index_out  = slot_index[i];
              res.handle_out = slot_handle[i];
              res.status     = rtt_pkg::ST_RETRY_LIMIT;
            end else if (slot_waits[i] > cfg.wait_ticks) begin
              slot_waits[i] = 16'd0;
              if (slot_sends[i] != 8'hFF) slot_sends[i] = slot_sends[i] + 8'd1;
              note            = '0;
              note.resend     = 1'b1;
              note.cmd_out    = slot_cmd[i];
              note.time_out   = slot_time[i];
              note.index_out  = slot_index[i];
              note.handle_out = slot_handle[i];
              owed_results    = {owed_results, note};
            end else if (slot_waits[i] != 16'hFFFF) begin
              slot_waits[i] = slot_waits[i] + 16'd1;
            end
          end
        end
      end
    endcase
    owed_results = {owed_results, res};
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // compare a result transfer with the oldest owed result
  task automatic check_result(input rtt_pkg::out_item_t got);
    rtt_pkg::out_item_t want;
    checked++;
    if (got.resend === 1'b1) resends++;
    if (got.status === rtt_pkg::ST_RETRY_LIMIT) limit_stops++;
    if (owed_results.size() == 0) begin
      mismatches++;
      $display("%0t: result %h arrived with none expected", $time, got);
    end else begin
      want = owed_results.pop_front();
      if (got !== want) begin
        mismatches++;
        compare_field("resend", want.resend, got.resend);
        compare_field("cmd_out", want.cmd_out, got.cmd_out);
        compare_field("time_out", want.time_out, got.time_out);
        compare_field("index_out", want.index_out, got.index_out);
        compare_field("handle_out", want.handle_out, got.handle_out);
        compare_field("status", want.status, got.status);
        compare_field("last", want.last, got.last);
      end
    end
  endtask

  // watch all three ports
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used           = '0;
      cfg.max_sends  = rtt_pkg::MAX_SENDS_RST;
      cfg.wait_ticks = rtt_pkg::WAIT_TICKS_RST;
      owed_results.delete();
      pending_o     <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_item_i);
      if (in_valid_i && in_ready_i) apply_table_op(in_item_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == rtt_pkg::REG_MAX_SENDS) cfg.max_sends = pwdata_i[7:0];
        else cfg.wait_ticks = pwdata_i[15:0];
      end
      pending_o <= owed_results.size();
    end
  end

endmodule

// File: dv/retransmit_timer_table_tb.sv
// retransmit_timer_table_tb: stimulus and verdict for the retransmit timer table
// drives directed and random operations and register writes; checking is done
// by retransmit_timer_table_checker; depends on rtt_pkg and the table rtl
`timescale 1ns / 100ps

module retransmit_timer_table_tb;

  localparam int KEY_POOL    = 24;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE      = rtt_pkg::TABLE_DEPTH + 4;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  rtt_pkg::in_item_t           in_item_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  rtt_pkg::out_item_t          out_item_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rtt_pkg::PADDR_W-1:0] paddr;
  logic [rtt_pkg::PDATA_W-1:0] pwdata;
  logic [rtt_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  int fail_count;
  int pending;
  int results;
  int resends;
  int limit_stops;

  // keys reused so that hits, duplicates and a full table occur
  logic [15:0] pool_cmd   [KEY_POOL];
  logic [31:0] pool_time  [KEY_POOL];
  logic [31:0] pool_index [KEY_POOL];

  int ops_sent    = 0;
  int ticks_sent  = 0;
  int idle_cycles = 0;
  int k;
  bit quiet       = 1'b0;

  retransmit_timer_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  retransmit_timer_table_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_item_i     (in_item_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_i    (out_item_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results),
    .resends_o     (resends),
    .limit_stops_o (limit_stops)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure in bursts, none in the quiet part
  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 9) < 3) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  function automatic rtt_pkg::in_item_t key_op(input rtt_pkg::func_e f, input int idx,
                                               input logic [7:0] h);
    rtt_pkg::in_item_t op;
    op.func         = f;
    op.cmd          = pool_cmd[idx];
    op.server_time  = pool_time[idx];
    op.packet_index = pool_index[idx];
    op.frame_handle = h;
    return op;
  endfunction

  // mostly pooled keys, some fully random ones
  function automatic rtt_pkg::in_item_t random_op();
    rtt_pkg::in_item_t op;
    rtt_pkg::func_e    f;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) f = rtt_pkg::FUNC_INSERT;
    else if (pick < 55) f = rtt_pkg::FUNC_DELETE;
    else if (pick < 70) f = rtt_pkg::FUNC_LOOKUP;
    else f = rtt_pkg::FUNC_TICK;
    if ($urandom_range(0, 9) < 8) begin
      op = key_op(f, $urandom_range(0, KEY_POOL - 1), 8'($urandom_range(0, 255)));
    end else begin
      op.func         = f;
      op.cmd          = 16'($urandom);
      op.server_time  = $urandom;
      op.packet_index = $urandom;
      op.frame_handle = 8'($urandom_range(0, 255));
    end
    return op;
  endfunction

  // one operation transfer, with an occasional gap before it
  task automatic send_op(input rtt_pkg::in_item_t op);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= op;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ops_sent++;
    if (op.func == rtt_pkg::FUNC_TICK) ticks_sent++;
  endtask

  // register write: setup then access phase
  task automatic write_reg(input logic [0:0] reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold off until every owed result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] sends, input logic [15:0] waits,
                           input int count);
    wait_idle();
    write_reg(rtt_pkg::REG_MAX_SENDS, {24'd0, sends});
    write_reg(rtt_pkg::REG_WAIT_TICKS, {16'd0, waits});
    repeat (count) send_op(random_op());
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;

    // key pool: all zeros, all ones, near misses of all ones, then random
    for (k = 0; k < KEY_POOL; k++) begin
      pool_cmd[k]   = 16'($urandom);
      pool_time[k]  = $urandom;
      pool_index[k] = $urandom;
    end
    pool_cmd[0] = 16'h0000;  pool_time[0] = 32'h0;         pool_index[0] = 32'h0;
    pool_cmd[1] = 16'hFFFF;  pool_time[1] = 32'hFFFF_FFFF; pool_index[1] = 32'hFFFF_FFFF;
    pool_cmd[2] = 16'hFFFF;  pool_time[2] = 32'hFFFF_FFFF; pool_index[2] = 32'hFFFF_FFFE;
    pool_cmd[3] = 16'hFFFF;  pool_time[3] = 32'h7FFF_FFFF; pool_index[3] = 32'hFFFF_FFFF;
    pool_cmd[4] = 16'hFFFE;  pool_time[4] = 32'hFFFF_FFFF; pool_index[4] = 32'hFFFF_FFFF;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero limits so resend and retry limit come quickly
    write_reg(rtt_pkg::REG_MAX_SENDS, 32'd0);
    write_reg(rtt_pkg::REG_WAIT_TICKS, 32'd0);
    send_op(key_op(rtt_pkg::FUNC_TICK, 0, 8'h00));
    send_op(key_op(rtt_pkg::FUNC_INSERT, 0, 8'h00));
    send_op(key_op(rtt_pkg::FUNC_INSERT, 1, 8'hFF));
    send_op(key_op(rtt_pkg::FUNC_INSERT, 1, 8'h5A));
    send_op(key_op(rtt_pkg::FUNC_LOOKUP, 1, 8'h00));
    send_op(key_op(rtt_pkg::FUNC_LOOKUP, 2, 8'h00));
    send_op(key_op(rtt_pkg::FUNC_DELETE, 3, 8'h00));
    // wait count up, resend, then retry limit stops on the later ticks
    repeat (4) send_op(key_op(rtt_pkg::FUNC_TICK, 0, 8'h00));
    send_op(key_op(rtt_pkg::FUNC_DELETE, 0, 8'h00));
    send_op(key_op(rtt_pkg::FUNC_LOOKUP, 0, 8'h00));
    // fill every slot, then one more insert hits a full table
    for (k = 4; k < 19; k++) send_op(key_op(rtt_pkg::FUNC_INSERT, k, k[7:0]));
    send_op(key_op(rtt_pkg::FUNC_INSERT, 19, 8'hA5));
    send_op(key_op(rtt_pkg::FUNC_TICK, 0, 8'h00));

    // random phases over several register settings
    run_phase(8'd255, 16'd65535, 45);
    run_phase(8'd1, 16'd0, 55);
    run_phase(8'd3, 16'd10, 50);
    run_phase(8'd0, 16'd2, 45);
    quiet = 1'b1;
    run_phase(8'd2, 16'd1, 40);
    wait_idle();

    $display("sent %0d operations (%0d ticks) across six register settings",
             ops_sent, ticks_sent);
    $display("checked %0d results, %0d resends and %0d retry-limit stops among them",
             results, resends, limit_stops);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
